[src/rnim_pkg.sv]
// Shared types and constants for the nearest-neighbor resize index map.
// No dependencies; every other file imports this package.
package rnim_pkg;

    localparam int COORD_W    = 12;   // out_coord / src_index
    localparam int SIZE_W     = 13;   // in_size / out_size
    localparam int SCALE_W    = 24;   // axis_scale, Q8.16
    localparam int MODE_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int SCALE_FRAC = 16;   // fraction bits of axis_scale
    localparam int DIV_BPS    = 3;    // quotient bits per divider stage

    localparam logic [SCALE_W-1:0] SCALE_ONE = 24'h01_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IN_SIZE    = 3'd0,
        REG_OUT_SIZE   = 3'd1,
        REG_AXIS_SCALE = 3'd2,
        REG_COORD_MODE = 3'd3,
        REG_ROUND_MODE = 3'd4
    } t_reg_idx;

    typedef enum logic [MODE_W-1:0] {
        CM_HALF_CENTER   = 3'd0,
        CM_PYTORCH_HALF  = 3'd1,
        CM_ASYMMETRIC    = 3'd2,
        CM_TF_HALF_NN    = 3'd3,
        CM_CORNER_ALIGN  = 3'd4
    } t_coord_mode;

    typedef enum logic [MODE_W-1:0] {
        RM_PREFER_FLOOR = 3'd0,
        RM_PREFER_CEIL  = 3'd1,
        RM_FLOOR        = 3'd2,
        RM_CEIL         = 3'd3,
        RM_SIMPLE       = 3'd4
    } t_round_mode;

    // How the divider operands are formed
    typedef enum logic [2:0] {
        P_IDENT = 3'd0,
        P_ZERO  = 3'd1,
        P_HALF  = 3'd2,
        P_ASYM  = 3'd3,
        P_ALIGN = 3'd4
    } t_path;

    // Rounding reduced to one offset before the floor shift
    typedef enum logic [1:0] {
        RK_FLOOR   = 2'd0,
        RK_CEIL    = 2'd1,
        RK_HALF_DN = 2'd2,
        RK_HALF_UP = 2'd3
    } t_rkind;

    // Decoded configuration; the user must keep it static while items are in flight
    typedef struct packed {
        t_path               path;
        logic                sub_half;
        t_rkind              rkind;
        logic [SIZE_W-1:0]   in_m1;
        logic [SIZE_W-1:0]   out_m1;
        logic [SCALE_W-1:0]  scale;
        logic [SIZE_W-1:0]   upper;
    } t_ctl;

endpackage

[src/rnim_front.sv]
// Operand stage: builds dividend and divisor for one coordinate.
// Depends on rnim_pkg.
module rnim_front #(
    parameter int FRAC_BITS = 16,
    parameter int DW        = 44
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [rnim_pkg::COORD_W-1:0]     i_out_coord,
    input  rnim_pkg::t_ctl                   i_ctl,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [DW-1:0]                    o_dividend,
    output logic [rnim_pkg::SCALE_W-1:0]     o_divisor
);
    import rnim_pkg::*;

    localparam int PROD_W = COORD_W + SIZE_W;
    localparam int BASE_W = COORD_W + FRAC_BITS;

    logic                 r_vld;
    logic [DW-1:0]        r_dvd;
    logic [DW-1:0]        n_dvd;
    logic [SCALE_W-1:0]   r_dvs;
    logic [SCALE_W-1:0]   n_dvs;
    logic [PROD_W-1:0]    prod;
    logic [BASE_W-1:0]    base;
    logic [BASE_W-1:0]    base_h;

    assign o_ready = !r_vld || i_ready;

    always_comb begin
        prod   = PROD_W'(i_out_coord) * PROD_W'(i_ctl.in_m1);
        base   = {i_out_coord, {FRAC_BITS{1'b0}}};
        base_h = {i_out_coord, 1'b1, {(FRAC_BITS-1){1'b0}}};  // base + half
        n_dvd  = '0;
        n_dvs  = SCALE_W'(1);
        case (i_ctl.path)
            P_IDENT: begin
                n_dvd = DW'(base);
            end
            P_HALF: begin
                n_dvd = DW'({base_h, {SCALE_FRAC{1'b0}}});
                n_dvs = i_ctl.scale;
            end
            P_ASYM: begin
                n_dvd = DW'({base, {SCALE_FRAC{1'b0}}});
                n_dvs = i_ctl.scale;
            end
            P_ALIGN: begin
                n_dvd = DW'({prod, {FRAC_BITS{1'b0}}});
                n_dvs = SCALE_W'(i_ctl.out_m1);
            end
            default: begin
                n_dvd = '0;   // forced zero coordinate
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_dvd <= n_dvd;
            r_dvs <= n_dvs;
        end
    end

    assign o_valid    = r_vld;
    assign o_dividend = r_dvd;
    assign o_divisor  = r_dvs;

endmodule

[src/rnim_div.sv]
// Pipelined restoring divider, BPS quotient bits per stage, per-stage stall.
// Depends on rnim_pkg.
module rnim_div #(
    parameter int DW  = 44,
    parameter int VW  = 24,
    parameter int BPS = 3
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [DW-1:0]  i_dividend,
    input  logic [VW-1:0]  i_divisor,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [DW-1:0]  o_quotient
);
    import rnim_pkg::*;

    localparam int NSTG = (DW + BPS - 1) / BPS;
    localparam int PW   = NSTG * BPS;

    // work: unconsumed dividend bits on top, quotient bits shifted in below
    typedef struct packed {
        logic [VW-1:0] rem;
        logic [PW-1:0] work;
    } t_acc;

    logic [NSTG-1:0]  r_vld;
    logic [VW-1:0]    r_rem  [NSTG];
    logic [PW-1:0]    r_work [NSTG];
    logic [VW-1:0]    r_dvs  [NSTG];
    t_acc             acc_in  [NSTG];
    t_acc             acc_out [NSTG];
    logic [VW-1:0]    dvs_in  [NSTG];
    logic [NSTG-1:0]  vld_in;
    logic [NSTG:0]    rdy;

    function automatic t_acc div_steps(t_acc a, logic [VW-1:0] d);
        t_acc          r;
        logic [VW:0]   t;
        r = a;
        for (int j = 0; j < BPS; j++) begin
            t      = {r.rem, r.work[PW-1]};
            r.work = {r.work[PW-2:0], 1'b0};
            if (t >= {1'b0, d}) begin
                r.rem     = VW'(t - {1'b0, d});
                r.work[0] = 1'b1;
            end else begin
                r.rem = t[VW-1:0];
            end
        end
        return r;
    endfunction

    always_comb begin
        rdy[NSTG] = i_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
        acc_in[0].rem  = '0;
        acc_in[0].work = PW'(i_dividend);
        dvs_in[0]      = i_divisor;
        vld_in[0]      = i_valid;
        for (int k = 1; k < NSTG; k++) begin
            acc_in[k].rem  = r_rem[k-1];
            acc_in[k].work = r_work[k-1];
            dvs_in[k]      = r_dvs[k-1];
            vld_in[k]      = r_vld[k-1];
        end
        for (int k = 0; k < NSTG; k++) begin
            acc_out[k] = div_steps(acc_in[k], dvs_in[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= vld_in[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NSTG; k++) begin
            if (rdy[k] && vld_in[k]) begin
                r_rem[k]  <= acc_out[k].rem;
                r_work[k] <= acc_out[k].work;
                r_dvs[k]  <= dvs_in[k];
            end
        end
    end

    assign o_ready    = rdy[0];
    assign o_valid    = r_vld[NSTG-1];
    assign o_quotient = r_work[NSTG-1][DW-1:0];

endmodule

[src/rnim_round.sv]
// Rounding and clamp stages: offset add with floor shift, then clamp.
// Depends on rnim_pkg.
module rnim_round #(
    parameter int FRAC_BITS = 16,
    parameter int DW        = 44
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [DW-1:0]                 i_quot,
    input  rnim_pkg::t_ctl                i_ctl,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [rnim_pkg::COORD_W-1:0]  o_src_index
);
    import rnim_pkg::*;

    localparam int SW = DW + 2;
    localparam int NW = SW - FRAC_BITS;
    localparam int OW = FRAC_BITS + 2;
    localparam logic signed [OW-1:0] C_HALF   = OW'(2 ** (FRAC_BITS - 1));
    localparam logic signed [OW-1:0] C_ONE_M1 = OW'(2 ** FRAC_BITS - 1);

    logic                     r_vld1;
    logic                     r_vld2;
    logic                     rdy1;
    logic                     rdy2;
    logic signed [OW-1:0]     ofs;
    logic signed [SW-1:0]     sum;
    logic signed [NW-1:0]     r_n;
    logic [SIZE_W-1:0]        res;
    logic [COORD_W-1:0]       r_idx;

    assign rdy2    = !r_vld2 || i_ready;
    assign rdy1    = !r_vld1 || rdy2;
    assign o_ready = rdy1;

    // ceil(x) = floor(x + 1 - ulp); halves shift by one half before the floor
    always_comb begin
        case (i_ctl.rkind)
            RK_CEIL:    ofs = C_ONE_M1;
            RK_HALF_DN: ofs = C_HALF - OW'(1);
            RK_HALF_UP: ofs = C_HALF;
            default:    ofs = '0;
        endcase
        if (i_ctl.sub_half) begin
            ofs = ofs - C_HALF;
        end
        sum = $signed({2'b00, i_quot}) + SW'(ofs);
    end

    always_comb begin
        if (r_n[NW-1]) begin
            res = '0;
        end else if (r_n > $signed({{(NW-SIZE_W){1'b0}}, i_ctl.upper})) begin
            res = i_ctl.upper;
        end else begin
            res = r_n[SIZE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_vld1 <= i_valid;
            end
            if (rdy2) begin
                r_vld2 <= r_vld1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_n <= sum[SW-1:FRAC_BITS];
        end
        if (rdy2 && r_vld1) begin
            r_idx <= res[COORD_W-1:0];
        end
    end

    assign o_valid     = r_vld2;
    assign o_src_index = r_idx;

endmodule

[src/resize_nearest_index_map.sv]
// Nearest-neighbor resize index map for one axis: config registers and pipeline.
// Depends on rnim_pkg, rnim_front, rnim_div, rnim_round.
// Pipeline: operand stage, divider stages (3 quotient bits each), then rounding and
// clamp stages. Throughput: one item per cycle while the output is not stalled.
// Reset: config returns to in_size 1, out_size 1, scale 1.0, half-pixel centers,
// round half down; all pipeline valids clear. Config port is always ready.
module resize_nearest_index_map #(
    parameter int MAX_SIZE  = 4096,
    parameter int FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rnim_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rnim_pkg::SCALE_W-1:0]    i_cfg_data,
    // coordinate in
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [rnim_pkg::COORD_W-1:0]    i_out_coord,
    // index out
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [rnim_pkg::COORD_W-1:0]    o_src_index
);
    import rnim_pkg::*;

    // Dividend is at most (coordinate + 1/2) * 2^FRAC_BITS * 2^16 (half-pixel paths)
    localparam int DW = COORD_W + FRAC_BITS + SCALE_FRAC;

    logic [SIZE_W-1:0]   r_in_size;
    logic [SIZE_W-1:0]   r_out_size;
    logic [SCALE_W-1:0]  r_axis_scale;
    logic [MODE_W-1:0]   r_coord_mode;
    logic [MODE_W-1:0]   r_round_mode;

    t_ctl                ctl;
    logic [SIZE_W-1:0]   isz;
    logic                ident;
    logic                out_big;

    logic                fr_valid;
    logic                fr_ready;
    logic [DW-1:0]       fr_dvd;
    logic [SCALE_W-1:0]  fr_dvs;
    logic                dv_valid;
    logic                dv_ready;
    logic [DW-1:0]       dv_quot;

    // Config registers; writes to unused indexes are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_size    <= SIZE_W'(1);
            r_out_size   <= SIZE_W'(1);
            r_axis_scale <= SCALE_ONE;
            r_coord_mode <= CM_HALF_CENTER;
            r_round_mode <= RM_PREFER_FLOOR;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_IN_SIZE:    r_in_size    <= i_cfg_data[SIZE_W-1:0];
                REG_OUT_SIZE:   r_out_size   <= i_cfg_data[SIZE_W-1:0];
                REG_AXIS_SCALE: r_axis_scale <= i_cfg_data;
                REG_COORD_MODE: r_coord_mode <= i_cfg_data[MODE_W-1:0];
                REG_ROUND_MODE: r_round_mode <= i_cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Config decode. The user must change config only with the pipeline empty (not enforced
    // here), as every stage reads it directly instead of carrying it along.
    always_comb begin
        isz     = (r_in_size == '0) ? SIZE_W'(1) : r_in_size;
        ident   = (r_axis_scale == SCALE_ONE) || (r_in_size == r_out_size);
        out_big = (r_out_size > SIZE_W'(1));

        ctl.scale  = (r_axis_scale == '0) ? SCALE_W'(1) : r_axis_scale;
        ctl.in_m1  = isz - SIZE_W'(1);
        ctl.out_m1 = r_out_size - SIZE_W'(1);

        // upper clamp bound saturates at MAX_SIZE - 1
        if (int'(isz) > MAX_SIZE) begin
            ctl.upper = SIZE_W'(MAX_SIZE - 1);
        end else begin
            ctl.upper = isz - SIZE_W'(1);
        end

        ctl.sub_half = 1'b0;
        if (ident) begin
            ctl.path = P_IDENT;
        end else begin
            case (r_coord_mode)
                CM_PYTORCH_HALF: begin
                    ctl.path     = out_big ? P_HALF : P_ZERO;
                    ctl.sub_half = out_big;
                end
                CM_ASYMMETRIC:    ctl.path = P_ASYM;
                CM_TF_HALF_NN:    ctl.path = P_HALF;
                CM_CORNER_ALIGN:  ctl.path = out_big ? P_ALIGN : P_ZERO;
                default: begin
                    // half-pixel centers, also for unknown codes
                    ctl.path     = P_HALF;
                    ctl.sub_half = 1'b1;
                end
            endcase
        end

        // Negative coordinates clamp to zero, so truncation acts as floor.
        case (r_round_mode)
            RM_PREFER_CEIL: ctl.rkind = RK_HALF_UP;
            RM_FLOOR:       ctl.rkind = RK_FLOOR;
            RM_CEIL:        ctl.rkind = RK_CEIL;
            RM_SIMPLE:      ctl.rkind = (r_axis_scale < SCALE_ONE) ? RK_CEIL : RK_FLOOR;
            default:        ctl.rkind = RK_HALF_DN;
        endcase
    end

    // Identity and forced-zero cases go through the divider with divisor 1.
    rnim_front #(
        .FRAC_BITS (FRAC_BITS),
        .DW        (DW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_out_coord (i_out_coord),
        .i_ctl       (ctl),
        .o_valid     (fr_valid),
        .i_ready     (fr_ready),
        .o_dividend  (fr_dvd),
        .o_divisor   (fr_dvs)
    );

    rnim_div #(
        .DW  (DW),
        .VW  (SCALE_W),
        .BPS (DIV_BPS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (fr_valid),
        .o_ready    (fr_ready),
        .i_dividend (fr_dvd),
        .i_divisor  (fr_dvs),
        .o_valid    (dv_valid),
        .i_ready    (dv_ready),
        .o_quotient (dv_quot)
    );

    // Rounding and clamp stages; ready passes back from the output combinationally.
    rnim_round #(
        .FRAC_BITS (FRAC_BITS),
        .DW        (DW)
    ) u_round (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (dv_valid),
        .o_ready     (dv_ready),
        .i_quot      (dv_quot),
        .i_ctl       (ctl),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_src_index (o_src_index)
    );

endmodule

[src/rnim_chk.sv]
// Port-level checker for resize_nearest_index_map, attached by bind.
// Depends on rnim_pkg.
module rnim_chk #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_ready,
    input  logic                          o_out_valid,
    input  logic                          i_out_ready,
    input  logic [rnim_pkg::COORD_W-1:0]  o_src_index
);
    import rnim_pkg::*;

    localparam int DW    = COORD_W + FRAC_BITS + SCALE_FRAC;
    localparam int NSTG  = (DW + DIV_BPS - 1) / DIV_BPS;
    localparam int DEPTH = NSTG + 3;
    localparam int CNT_W = $clog2(DEPTH + 2);

    logic              in_acc;
    logic              out_acc;
    logic [CNT_W-1:0]  r_cnt;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    // items in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_acc && !out_acc) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end else if (!in_acc && out_acc) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_src_index))
        else $error("stalled result dropped or changed");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_cnt != '0))
        else $error("result with no item in flight");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("more items in flight than pipeline stages");

endmodule

bind resize_nearest_index_map rnim_chk #(.FRAC_BITS(FRAC_BITS)) u_rnim_chk (.*);
